/* rtl/core/bdc_pkg.sv */
// ----------------------------------------------------------------------------
// bdc_pkg
// Shared codes, register map, masks and CRC helpers of the download controller.
// ----------------------------------------------------------------------------
`default_nettype none

package bdc_pkg;

  localparam int WordsPerPacketDefault = 123;
  localparam int DramAddrBitsDefault   = 21;

  localparam int OpcodeW = 2;
  localparam int RegAddrW = 3;
  localparam int DataW = 16;
  localparam int FileIdW = 14;
  localparam int PacketAddrW = 15;
  localparam int PipeW = 4;
  localparam int CrcW = 32;

  // Operation codes carried by the opcode field.
  localparam logic [OpcodeW-1:0] OP_READ   = 2'd0;
  localparam logic [OpcodeW-1:0] OP_WRITE  = 2'd1;
  localparam logic [OpcodeW-1:0] OP_PACKET = 2'd2;

  // Register map.
  localparam logic [RegAddrW-1:0] REG_GAME_ID = 3'd0;
  localparam logic [RegAddrW-1:0] REG_MATCH   = 3'd1;
  localparam logic [RegAddrW-1:0] REG_CURRENT = 3'd2;
  localparam logic [RegAddrW-1:0] REG_STATUS  = 3'd3;
  localparam logic [RegAddrW-1:0] REG_CONTROL = 3'd4;
  localparam logic [RegAddrW-1:0] REG_CRC_IN  = 3'd5;
  localparam logic [RegAddrW-1:0] REG_CRC_LO  = 3'd6;
  localparam logic [RegAddrW-1:0] REG_CRC_HI  = 3'd7;

  localparam logic [CrcW-1:0]  CRC_POLY     = 32'h04C1_1DB7;
  localparam logic [DataW-1:0] CONTROL_MASK = 16'h012E;
  localparam logic [DataW-1:0] MATCH_RESET  = 16'h7FFF;

  // Control and status bit positions.
  localparam int CTRL_BOOT_A   = 0;
  localparam int CTRL_ENABLE   = 1;
  localparam int CTRL_MATCH_RS = 2;
  localparam int CTRL_BOOT_B   = 3;
  localparam int CTRL_CRC_CLR  = 4;
  localparam int STAT_DONE     = 0;

  // Flags of one result transaction.
  typedef struct packed {
    logic store_packet;
    logic download_done;
    logic boot_pulse;
  } flags_t;

  // Feeds one 16-bit word into the CRC, most significant bit first.
  // The chain is pure XOR logic and flattens into a parallel CRC network.
  function automatic logic [CrcW-1:0] crc_feed(input logic [CrcW-1:0] crc,
                                               input logic [DataW-1:0] word);
    logic [CrcW-1:0] c;
    logic            fb;
    c = crc;
    for (int i = DataW - 1; i >= 0; i--) begin
      fb = word[i] ^ c[CrcW-1];
      c  = {c[CrcW-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
    end
    return c;
  endfunction

  function automatic logic [CrcW-1:0] bit_reverse(input logic [CrcW-1:0] v);
    logic [CrcW-1:0] r;
    for (int i = 0; i < CrcW; i++) begin
      r[CrcW-1-i] = v[i];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/bdc_if.sv */
// ----------------------------------------------------------------------------
// bdc_req_if / bdc_rsp_if
// Valid/ready channels for request and result transactions.
// ----------------------------------------------------------------------------
`default_nettype none

interface bdc_req_if;
  logic                                valid;
  logic                                ready;
  logic [bdc_pkg::OpcodeW-1:0]         opcode;
  logic [bdc_pkg::RegAddrW-1:0]        reg_addr;
  logic [bdc_pkg::DataW-1:0]           wdata;
  logic [bdc_pkg::FileIdW-1:0]         file_id;
  logic [bdc_pkg::PacketAddrW-1:0]     packet_address;
  logic [bdc_pkg::PipeW-1:0]           pipe_index;

  modport source (output valid, opcode, reg_addr, wdata, file_id, packet_address,
                  pipe_index, input ready);
  modport sink (input valid, opcode, reg_addr, wdata, file_id, packet_address,
                pipe_index, output ready);
endinterface

interface bdc_rsp_if #(
  parameter int DRAM_ADDR_BITS = bdc_pkg::DramAddrBitsDefault
);
  logic                      valid;
  logic                      ready;
  logic [bdc_pkg::DataW-1:0] rdata;
  logic                      store_packet;
  logic [DRAM_ADDR_BITS-1:0] dram_word_base;
  logic                      download_done;
  logic                      boot_pulse;

  modport source (output valid, rdata, store_packet, dram_word_base, download_done,
                  boot_pulse, input ready);
  modport sink (input valid, rdata, store_packet, dram_word_base, download_done,
                boot_pulse, output ready);
endinterface

`default_nettype wire

/* rtl/core/bdc_core.sv */
// ----------------------------------------------------------------------------
// bdc_core
// Register file, CRC unit and packet match logic; computes one result per
// accepted transaction and updates the state in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bdc_core #(
  parameter int WORDS_PER_PACKET = bdc_pkg::WordsPerPacketDefault,
  parameter int DRAM_ADDR_BITS   = bdc_pkg::DramAddrBitsDefault
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                accept,
  input  wire logic [bdc_pkg::OpcodeW-1:0]         opcode,
  input  wire logic [bdc_pkg::RegAddrW-1:0]        reg_addr,
  input  wire logic [bdc_pkg::DataW-1:0]           wdata,
  input  wire logic [bdc_pkg::FileIdW-1:0]         file_id,
  input  wire logic [bdc_pkg::PacketAddrW-1:0]     packet_address,
  input  wire logic [bdc_pkg::PipeW-1:0]           pipe_index,
  output logic      [bdc_pkg::DataW-1:0]           rdata,
  output logic      [DRAM_ADDR_BITS-1:0]           dram_word_base,
  output bdc_pkg::flags_t                          flags
);

  localparam int WppW  = $clog2(WORDS_PER_PACKET + 1);
  localparam int ProdW = bdc_pkg::PacketAddrW + WppW + DRAM_ADDR_BITS;

  logic [bdc_pkg::DataW-1:0] game_select, game_select_next;
  logic [bdc_pkg::DataW-1:0] match_address, match_address_next;
  logic [bdc_pkg::DataW-1:0] current_address, current_address_next;
  logic [bdc_pkg::DataW-1:0] status_bits, status_bits_next;
  logic [bdc_pkg::DataW-1:0] control_bits, control_bits_next;
  logic [bdc_pkg::CrcW-1:0]  crc_value, crc_value_next;

  logic [bdc_pkg::CrcW-1:0]  crc_rev;
  logic [bdc_pkg::DataW-1:0] pkt_addr_ext;
  logic [ProdW-1:0]          product;
  logic                      hit;

  assign crc_rev      = bdc_pkg::bit_reverse(crc_value);
  assign pkt_addr_ext = bdc_pkg::DataW'(packet_address);
  assign product      = ProdW'(packet_address) * ProdW'(WORDS_PER_PACKET);

  // A packet with file id zero is only taken from the first pipe.
  assign hit = control_bits[bdc_pkg::CTRL_ENABLE] &&
               (bdc_pkg::DataW'(file_id) == game_select) &&
               !((file_id == '0) && (pipe_index != '0));

  always_comb begin
    game_select_next     = game_select;
    match_address_next   = match_address;
    current_address_next = current_address;
    status_bits_next     = status_bits;
    control_bits_next    = control_bits;
    crc_value_next       = crc_value;
    rdata                = '0;
    dram_word_base       = '0;
    flags                = '0;

    unique case (opcode)
      bdc_pkg::OP_READ: begin
        unique case (reg_addr)
          bdc_pkg::REG_GAME_ID: rdata = game_select;
          bdc_pkg::REG_MATCH:   rdata = match_address;
          bdc_pkg::REG_CURRENT: rdata = current_address;
          bdc_pkg::REG_STATUS:  rdata = status_bits;
          bdc_pkg::REG_CONTROL: rdata = control_bits;
          bdc_pkg::REG_CRC_LO:  rdata = crc_rev[bdc_pkg::DataW-1:0];
          bdc_pkg::REG_CRC_HI:  rdata = crc_rev[bdc_pkg::CrcW-1:bdc_pkg::DataW];
          default:              rdata = '0;
        endcase
      end
      bdc_pkg::OP_WRITE: begin
        unique case (reg_addr)
          bdc_pkg::REG_GAME_ID: game_select_next = wdata;
          bdc_pkg::REG_MATCH:   match_address_next = wdata;
          bdc_pkg::REG_CURRENT: current_address_next = wdata;
          bdc_pkg::REG_STATUS:  status_bits_next = status_bits & ~wdata;
          bdc_pkg::REG_CONTROL: begin
            control_bits_next = wdata & bdc_pkg::CONTROL_MASK;
            if (wdata[bdc_pkg::CTRL_MATCH_RS]) begin
              match_address_next = bdc_pkg::MATCH_RESET;
            end
            if (wdata[bdc_pkg::CTRL_CRC_CLR]) begin
              crc_value_next = '0;
            end
            flags.boot_pulse = wdata[bdc_pkg::CTRL_BOOT_A] & wdata[bdc_pkg::CTRL_BOOT_B];
          end
          bdc_pkg::REG_CRC_IN:  crc_value_next = bdc_pkg::crc_feed(crc_value, wdata);
          default: ;
        endcase
      end
      bdc_pkg::OP_PACKET: begin
        if (hit) begin
          current_address_next = pkt_addr_ext;
          if (pkt_addr_ext == match_address) begin
            status_bits_next[bdc_pkg::STAT_DONE]    = 1'b1;
            control_bits_next[bdc_pkg::CTRL_ENABLE] = 1'b0;
            flags.download_done                     = 1'b1;
          end else begin
            flags.store_packet = 1'b1;
            dram_word_base     = product[DRAM_ADDR_BITS-1:0];
            if (pkt_addr_ext < match_address) begin
              match_address_next = pkt_addr_ext;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      game_select     <= '0;
      match_address   <= bdc_pkg::MATCH_RESET;
      current_address <= '0;
      status_bits     <= '0;
      control_bits    <= '0;
      crc_value       <= '0;
    end else if (accept) begin
      game_select     <= game_select_next;
      match_address   <= match_address_next;
      current_address <= current_address_next;
      status_bits     <= status_bits_next;
      control_bits    <= control_bits_next;
      crc_value       <= crc_value_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/bdc_result_reg.sv */
// ----------------------------------------------------------------------------
// bdc_result_reg
// Output register of the result channel; loads whenever it is empty or its
// current transaction is taken in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bdc_result_reg #(
  parameter int DRAM_ADDR_BITS = bdc_pkg::DramAddrBitsDefault
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       load,
  output logic                            can_load,
  input  wire logic [bdc_pkg::DataW-1:0]  rdata,
  input  wire logic [DRAM_ADDR_BITS-1:0]  dram_word_base,
  input  wire bdc_pkg::flags_t            flags,
  bdc_rsp_if.source                       rsp
);

  logic                      valid;
  logic [bdc_pkg::DataW-1:0] rdata_q;
  logic [DRAM_ADDR_BITS-1:0] base_q;
  bdc_pkg::flags_t           flags_q;

  assign can_load = !valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_load) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      rdata_q <= rdata;
      base_q  <= dram_word_base;
      flags_q <= flags;
    end
  end

  assign rsp.valid          = valid;
  assign rsp.rdata          = rdata_q;
  assign rsp.dram_word_base = base_q;
  assign rsp.store_packet   = flags_q.store_packet;
  assign rsp.download_done  = flags_q.download_done;
  assign rsp.boot_pulse     = flags_q.boot_pulse;

endmodule

`default_nettype wire

/* rtl/core/broadcast_download_controller_unit.sv */
// ----------------------------------------------------------------------------
// broadcast_download_controller_unit
// Register block of a cable download adapter: bus reads and writes, packet
// header matching, DRAM store addressing and a 16-bit-fed CRC-32.
// ----------------------------------------------------------------------------
// A result is registered and valid in the cycle after its request transaction is accepted.
// Throughput: one transaction per cycle; the result register frees a slot in
// the same cycle it is taken, so only a stalled result channel stalls requests.
// Reset (rst, synchronous): match address 0x7fff, all other registers and the
// CRC cleared, result register empty.
`default_nettype none

module broadcast_download_controller_unit #(
  parameter int WORDS_PER_PACKET = bdc_pkg::WordsPerPacketDefault,
  parameter int DRAM_ADDR_BITS   = bdc_pkg::DramAddrBitsDefault
) (
  input wire logic  clk,
  input wire logic  rst,
  bdc_req_if.sink   req,
  bdc_rsp_if.source rsp
);

  logic                      can_load;
  logic                      accept;
  logic [bdc_pkg::DataW-1:0] rdata;
  logic [DRAM_ADDR_BITS-1:0] dram_word_base;
  bdc_pkg::flags_t           flags;

  assign req.ready = can_load;
  assign accept    = req.valid && can_load;

  bdc_core #(
    .WORDS_PER_PACKET (WORDS_PER_PACKET),
    .DRAM_ADDR_BITS   (DRAM_ADDR_BITS)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .opcode         (req.opcode),
    .reg_addr       (req.reg_addr),
    .wdata          (req.wdata),
    .file_id        (req.file_id),
    .packet_address (req.packet_address),
    .pipe_index     (req.pipe_index),
    .rdata          (rdata),
    .dram_word_base (dram_word_base),
    .flags          (flags)
  );

  bdc_result_reg #(
    .DRAM_ADDR_BITS (DRAM_ADDR_BITS)
  ) u_result_reg (
    .clk            (clk),
    .rst            (rst),
    .load           (req.valid),
    .can_load       (can_load),
    .rdata          (rdata),
    .dram_word_base (dram_word_base),
    .flags          (flags),
    .rsp            (rsp)
  );

endmodule

`default_nettype wire
